FILE: rtl/sbfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared codes and types for the byte-stuffing frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

    // Parser modes
    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_BODY = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_ESC_END  = 3'd2;
    localparam logic [2:0] ST_BAD_ESC  = 3'd3;
    localparam logic [2:0] ST_NO_CLOSE = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_DELIMITER  = 3'd0;
    localparam logic [2:0] REG_ESCAPE     = 3'd1;
    localparam logic [2:0] REG_ESC_DELIM  = 3'd2;
    localparam logic [2:0] REG_ESC_ESCAPE = 3'd3;
    localparam logic [2:0] REG_MAX_LEN    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_DELIMITER  = 8'd192;
    localparam logic [7:0]  RST_ESCAPE     = 8'd219;
    localparam logic [7:0]  RST_ESC_DELIM  = 8'd220;
    localparam logic [7:0]  RST_ESC_ESCAPE = 8'd221;
    localparam logic [15:0] RST_MAX_LEN    = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  delimiter_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  escaped_delimiter_code;
        logic [7:0]  escaped_escape_code;
        logic [15:0] max_payload;
    } sbfd_cfg_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [2:0]  status;
        logic [15:0] frame_length;
    } sbfd_result_t;

endpackage
`default_nettype wire

FILE: rtl/byte_stuff_frame_decoder_core.sv
`default_nettype none
// A result reaches the m_ side via the output register, or via the skid entry
// if it is held. Throughput: one input beat per cycle while the skid is empty,
// set by the combinational parse step and output register with one-entry skid.
// Reset (aresetn low, synchronous): parser back to hunting, count cleared,
// output and skid stages emptied, configuration back to its reset values.
// ----------------------------------------------------------------------------
// byte_stuff_frame_decoder_core
// Byte-stuffed frame decoder: hunts for a delimiter, unescapes the payload,
// and reports frame end with status and decoded length.
// ----------------------------------------------------------------------------
module byte_stuff_frame_decoder_core
    import sbfd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    // Received bytes
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    input  wire logic         s_axis_tlast,   // last_of_input

    // Decoded results
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [7:0] data_byte, [10:8] status,
                                              // [26:11] frame_length, [31:27] zero
    output logic              m_axis_tuser,   // data_valid
    output logic              m_axis_tlast,   // frame_end

    // Configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken, unknown indexes drop
    // ------------------------------------------------------------------
    sbfd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delimiter_byte         <= RST_DELIMITER;
            cfg_reg.escape_byte            <= RST_ESCAPE;
            cfg_reg.escaped_delimiter_code <= RST_ESC_DELIM;
            cfg_reg.escaped_escape_code    <= RST_ESC_ESCAPE;
            cfg_reg.max_payload            <= RST_MAX_LEN;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DELIMITER:  cfg_reg.delimiter_byte         <= cfg_data[7:0];
                REG_ESCAPE:     cfg_reg.escape_byte            <= cfg_data[7:0];
                REG_ESC_DELIM:  cfg_reg.escaped_delimiter_code <= cfg_data[7:0];
                REG_ESC_ESCAPE: cfg_reg.escaped_escape_code    <= cfg_data[7:0];
                REG_MAX_LEN:    cfg_reg.max_payload            <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parse step: decode the incoming beat against the current state
    // ------------------------------------------------------------------
    logic         in_beat;
    sbfd_result_t step_result;
    logic         step_present;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    sbfd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .byte_take      (in_beat),
        .in_byte        (s_axis_tdata),
        .last_of_input  (s_axis_tlast),
        .result         (step_result),
        .result_present (step_present)
    );

    // ------------------------------------------------------------------
    // Output register plus one skid entry. The input side stalls only
    // while the skid entry is occupied, so ready never depends on
    // m_axis_tready combinationally.
    // ------------------------------------------------------------------
    sbfd_result_t out_reg,  out_next;
    logic         out_valid_reg, out_valid_next;
    sbfd_result_t skid_reg, skid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic         out_beat;
    logic         new_result;

    assign s_axis_tready = !skid_valid_reg;
    assign out_beat      = out_valid_reg && m_axis_tready;
    assign new_result    = in_beat && step_present;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg) begin
            // No new beat can arrive here; drain the skid entry forward
            if (out_beat) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || out_beat) begin
            // Output stage free this cycle: load straight into it
            out_next       = step_result;
            out_valid_next = new_result;
        end else if (new_result) begin
            // Output stage held: park the result in the skid entry
            skid_next       = step_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.data_valid;
    assign m_axis_tlast  = out_reg.frame_end;
    assign m_axis_tdata  = {5'd0, out_reg.frame_length, out_reg.status, out_reg.data_byte};

endmodule
`default_nettype wire

FILE: rtl/sbfd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbfd_parser
// Frame parse state and per-byte decode; one byte is consumed per beat.
// ----------------------------------------------------------------------------
module sbfd_parser
    import sbfd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire sbfd_cfg_t    cfg,
    input  wire logic         byte_take,
    input  wire logic [7:0]   in_byte,
    input  wire logic         last_of_input,
    output sbfd_result_t      result,
    output logic              result_present
);

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] count_reg, count_next;

    logic        have_byte;
    logic [7:0]  lit;
    logic [16:0] count_inc;

    assign count_inc = {1'b0, count_reg} + 17'd1;

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        have_byte  = 1'b0;
        lit        = 8'd0;
        result     = '0;
        result.status = ST_OK;

        case (mode_reg)
            MODE_BODY: begin
                if (in_byte == cfg.delimiter_byte) begin
                    result.frame_end    = 1'b1;
                    result.status       = ST_OK;
                    result.frame_length = count_reg;
                end else if (in_byte == cfg.escape_byte) begin
                    if (last_of_input) begin
                        result.frame_end = 1'b1;
                        result.status    = ST_ESC_END;
                    end else begin
                        mode_next = MODE_ESC;
                    end
                end else begin
                    have_byte = 1'b1;
                    lit       = in_byte;
                end
            end
            MODE_ESC: begin
                if (in_byte == cfg.escaped_delimiter_code) begin
                    have_byte = 1'b1;
                    lit       = cfg.delimiter_byte;
                end else if (in_byte == cfg.escaped_escape_code) begin
                    have_byte = 1'b1;
                    lit       = cfg.escape_byte;
                end else begin
                    result.frame_end = 1'b1;
                    result.status    = ST_BAD_ESC;
                end
            end
            default: begin
                // Hunting: wait for an opening delimiter
                if (in_byte == cfg.delimiter_byte) begin
                    mode_next  = MODE_BODY;
                    count_next = 16'd0;
                end
            end
        endcase

        if (have_byte) begin
            if (count_inc > {1'b0, cfg.max_payload}) begin
                result.frame_end = 1'b1;
                result.status    = ST_OVERFLOW;
            end else begin
                result.data_valid = 1'b1;
                result.data_byte  = lit;
                count_next        = count_inc[15:0];
                mode_next         = MODE_BODY;
            end
        end

        if (last_of_input && !result.frame_end) begin
            result.frame_end = 1'b1;
            result.status    = ST_NO_CLOSE;
        end

        if (result.frame_end) begin
            mode_next  = MODE_HUNT;
            count_next = 16'd0;
        end

        result_present = result.data_valid | result.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_HUNT;
            count_reg <= 16'd0;
        end else if (byte_take) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire
